// File: hdl/trci_pkg.sv
// trci_pkg: shared constants for the triangle raster color interpolate block
// field widths, parameter defaults and configuration register indexes
// no dependencies
package trci_pkg;

    localparam int COORD_BITS_DEF    = 10;
    localparam int FRACTION_BITS_DEF = 4;
    localparam int COLOR_BITS_DEF    = 16;

    localparam int PIX_W  = 10;   // pixel and result coordinate fields
    localparam int CHAN_W = 16;   // one color slot
    localparam int VTX_W  = 32;   // packed vertex register
    localparam int COL_W  = 48;   // packed color register
    localparam int CFG_W  = 48;   // write data, widest register
    localparam int IDX_W  = 3;    // register index
    localparam int VC_W   = 16;   // one vertex coordinate, signed
    localparam int DET_W  = 2 * (VC_W + 1) + 1;

    localparam logic [IDX_W-1:0] REG_VERTEX_A     = 3'd0;
    localparam logic [IDX_W-1:0] REG_VERTEX_B     = 3'd1;
    localparam logic [IDX_W-1:0] REG_VERTEX_C     = 3'd2;
    localparam logic [IDX_W-1:0] REG_TINT         = 3'd3;
    localparam logic [IDX_W-1:0] REG_COLOR_FIRST  = 3'd4;
    localparam logic [IDX_W-1:0] REG_COLOR_SECOND = 3'd5;
    localparam logic [IDX_W-1:0] REG_COLOR_THIRD  = 3'd6;

endpackage

// File: hdl/trci_pix_if.sv
// trci_pix_if: pixel coordinate channel, valid/ready handshake
// depends on trci_pkg
interface trci_pix_if;
    logic                        valid;
    logic                        ready;
    logic [trci_pkg::PIX_W-1:0]  pixel_x;
    logic [trci_pkg::PIX_W-1:0]  pixel_y;

    modport source(output valid, pixel_x, pixel_y, input ready);
    modport sink(input valid, pixel_x, pixel_y, output ready);
endinterface

// File: hdl/trci_res_if.sv
// trci_res_if: covered pixel result channel, valid/ready handshake
// depends on trci_pkg
interface trci_res_if;
    logic                        valid;
    logic                        ready;
    logic [trci_pkg::PIX_W-1:0]  out_x;
    logic [trci_pkg::PIX_W-1:0]  out_y;
    logic [trci_pkg::CHAN_W-1:0] red;
    logic [trci_pkg::CHAN_W-1:0] green;
    logic [trci_pkg::CHAN_W-1:0] blue;

    modport source(output valid, out_x, out_y, red, green, blue, input ready);
    modport sink(input valid, out_x, out_y, red, green, blue, output ready);
endinterface

// File: hdl/trci_front.sv
// trci_front: three stage coverage test and barycentric numerators
// vertex rotation, edge tests, determinant; depends on trci_pkg
module trci_front #(
    parameter int COORD_BITS    = trci_pkg::COORD_BITS_DEF,
    parameter int FRACTION_BITS = trci_pkg::FRACTION_BITS_DEF,
    localparam int XW   = COORD_BITS + FRACTION_BITS,
    localparam int DW   = ((XW + 1 > trci_pkg::VC_W + 1) ? XW + 1 : trci_pkg::VC_W + 1) + 1,
    localparam int PW   = trci_pkg::VC_W + 1 + DW,
    localparam int PNW  = PW + 1,
    localparam int DETW = trci_pkg::DET_W
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_adv,
    input  logic                          i_valid,
    input  logic [COORD_BITS-1:0]         i_px,
    input  logic [COORD_BITS-1:0]         i_py,
    input  logic [trci_pkg::VTX_W-1:0]    i_vtx_a,
    input  logic [trci_pkg::VTX_W-1:0]    i_vtx_b,
    input  logic [trci_pkg::VTX_W-1:0]    i_vtx_c,
    output logic                          o_valid,
    output logic [COORD_BITS-1:0]         o_px,
    output logic [COORD_BITS-1:0]         o_py,
    output logic                          o_hit,
    output logic signed [PNW-1:0]         o_pn,
    output logic signed [PNW-1:0]         o_qn,
    output logic signed [DETW-1:0]        o_det
);
    localparam int VW = trci_pkg::VC_W;

    function automatic logic [1:0] inc3(input logic [1:0] v);
        return (v == 2'd2) ? 2'd0 : v + 2'd1;
    endfunction

    logic signed [VW-1:0] vx [3];
    logic signed [VW-1:0] vy [3];
    logic [1:0] o1, ia, ib, ic;
    logic signed [VW-1:0] ax, ay, bx, by, cx, cy;
    logic signed [VW-1:0] mid_x, far_x, e3px, e3py, e3qx, e3qy;
    logic case1;
    logic signed [VW:0] ab_dx, ab_dy, ac_dx, ac_dy, e3_dx, e3_dy;
    logic signed [VW:0] dbx, dby, dcx, dcy;
    logic signed [DW-1:0] xs, ys;

    assign vx[0] = $signed(i_vtx_a[31:16]);
    assign vy[0] = $signed(i_vtx_a[15:0]);
    assign vx[1] = $signed(i_vtx_b[31:16]);
    assign vy[1] = $signed(i_vtx_b[15:0]);
    assign vx[2] = $signed(i_vtx_c[31:16]);
    assign vy[2] = $signed(i_vtx_c[15:0]);

    // rotate (a,b,c) -> (c,a,b) at most twice until the leftmost comes first
    always_comb begin
        o1 = (vx[0] > vx[1] || vx[0] > vx[2]) ? 2'd2 : 2'd0;
        ia = o1;
        if (vx[o1] > vx[inc3(o1)] || vx[o1] > vx[inc3(inc3(o1))]) begin
            ia = inc3(inc3(o1));
        end
        ib = inc3(ia);
        ic = inc3(ib);
    end

    assign ax = vx[ia];
    assign ay = vy[ia];
    assign bx = vx[ib];
    assign by = vy[ib];
    assign cx = vx[ic];
    assign cy = vy[ic];

    assign case1 = (cx <= bx);
    assign mid_x = case1 ? cx : bx;
    assign far_x = case1 ? bx : cx;
    // edge split at the middle vertex, always taken left to right
    assign e3px  = case1 ? cx : bx;
    assign e3py  = case1 ? cy : by;
    assign e3qx  = case1 ? bx : cx;
    assign e3qy  = case1 ? by : cy;

    assign ab_dx = (VW+1)'(bx) - (VW+1)'(ax);
    assign ab_dy = (VW+1)'(by) - (VW+1)'(ay);
    assign ac_dx = (VW+1)'(cx) - (VW+1)'(ax);
    assign ac_dy = (VW+1)'(cy) - (VW+1)'(ay);
    assign e3_dx = (VW+1)'(e3qx) - (VW+1)'(e3px);
    assign e3_dy = (VW+1)'(e3qy) - (VW+1)'(e3py);
    assign dbx   = (VW+1)'(vx[1]) - (VW+1)'(vx[0]);
    assign dby   = (VW+1)'(vy[1]) - (VW+1)'(vy[0]);
    assign dcx   = (VW+1)'(vx[2]) - (VW+1)'(vx[0]);
    assign dcy   = (VW+1)'(vy[2]) - (VW+1)'(vy[0]);

    assign xs = $signed(DW'(XW'(i_px) << FRACTION_BITS));
    assign ys = $signed(DW'(XW'(i_py) << FRACTION_BITS));

    // stage 1: offsets from the edge start points and column ranges
    logic                   r1_valid;
    logic [COORD_BITS-1:0]  r1_px, r1_py;
    logic signed [DW-1:0]   r1_ab_ex, r1_ab_ey, r1_ac_ex, r1_ac_ey;
    logic signed [DW-1:0]   r1_e3_ex, r1_e3_ey, r1_b_ex, r1_b_ey;
    logic                   r1_rng1, r1_rng2;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r1_valid <= 1'b0;
        end else if (i_adv) begin
            r1_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_adv) begin
            r1_px    <= i_px;
            r1_py    <= i_py;
            r1_ab_ex <= xs - DW'(ax);
            r1_ab_ey <= ys - DW'(ay);
            r1_ac_ex <= xs - DW'(ax);
            r1_ac_ey <= ys - DW'(ay);
            r1_e3_ex <= xs - DW'(e3px);
            r1_e3_ey <= ys - DW'(e3py);
            r1_b_ex  <= xs - DW'(vx[0]);
            r1_b_ey  <= ys - DW'(vy[0]);
            r1_rng1  <= (xs >= DW'(ax)) && (xs <= DW'(mid_x)) && (mid_x != ax);
            r1_rng2  <= (xs > DW'(mid_x)) && (xs <= DW'(far_x));
        end
    end

    // stage 2: edge and barycentric products
    logic                   r2_valid;
    logic [COORD_BITS-1:0]  r2_px, r2_py;
    logic signed [PW-1:0]   r2_ab_l, r2_ab_r, r2_ac_l, r2_ac_r, r2_e3_l, r2_e3_r;
    logic signed [PW-1:0]   r2_pn_a, r2_pn_b, r2_qn_a, r2_qn_b;
    logic signed [DETW-1:0] r2_det_a, r2_det_b;
    logic                   r2_rng1, r2_rng2;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r2_valid <= 1'b0;
        end else if (i_adv) begin
            r2_valid <= r1_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_adv) begin
            r2_px    <= r1_px;
            r2_py    <= r1_py;
            r2_ab_l  <= PW'(ab_dy) * PW'(r1_ab_ex);
            r2_ab_r  <= PW'(r1_ab_ey) * PW'(ab_dx);
            r2_ac_l  <= PW'(ac_dy) * PW'(r1_ac_ex);
            r2_ac_r  <= PW'(r1_ac_ey) * PW'(ac_dx);
            r2_e3_l  <= PW'(e3_dy) * PW'(r1_e3_ex);
            r2_e3_r  <= PW'(r1_e3_ey) * PW'(e3_dx);
            r2_pn_a  <= PW'(dcy) * PW'(r1_b_ex);
            r2_pn_b  <= PW'(dcx) * PW'(r1_b_ey);
            r2_qn_a  <= PW'(dbx) * PW'(r1_b_ey);
            r2_qn_b  <= PW'(dby) * PW'(r1_b_ex);
            r2_det_a <= DETW'(dbx) * DETW'(dcy);
            r2_det_b <= DETW'(dcx) * DETW'(dby);
            r2_rng1  <= r1_rng1;
            r2_rng2  <= r1_rng2;
        end
    end

    // stage 3: edge compares and differences
    logic ab_above, ac_below, e3_above, e3_below, hit;

    assign ab_above = (r2_ab_l <= r2_ab_r);
    assign ac_below = (r2_ac_l >= r2_ac_r);
    assign e3_above = (r2_e3_l <= r2_e3_r);
    assign e3_below = (r2_e3_l >= r2_e3_r);
    assign hit = r2_rng1 ? (ab_above && ac_below)
               : (r2_rng2 && (case1 ? (ab_above && e3_below) : (e3_above && ac_below)));

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            o_valid <= 1'b0;
        end else if (i_adv) begin
            o_valid <= r2_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_adv) begin
            o_px  <= r2_px;
            o_py  <= r2_py;
            o_hit <= hit;
            o_pn  <= PNW'(r2_pn_a) - PNW'(r2_pn_b);
            o_qn  <= PNW'(r2_qn_a) - PNW'(r2_qn_b);
            o_det <= r2_det_a - r2_det_b;
        end
    end

endmodule

// File: hdl/trci_blend.sv
// trci_blend: two stage color blend numerator per channel
// products with the vertex colors, then the signed sum; depends on trci_pkg
module trci_blend #(
    parameter int COORD_BITS = trci_pkg::COORD_BITS_DEF,
    parameter int COLOR_BITS = trci_pkg::COLOR_BITS_DEF,
    parameter int PNW        = 36,
    localparam int NW   = PNW + COLOR_BITS + 3,
    localparam int DETW = trci_pkg::DET_W
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_adv,
    input  logic                        i_valid,
    input  logic [COORD_BITS-1:0]       i_px,
    input  logic [COORD_BITS-1:0]       i_py,
    input  logic                        i_hit,
    input  logic signed [PNW-1:0]       i_pn,
    input  logic signed [PNW-1:0]       i_qn,
    input  logic signed [DETW-1:0]      i_det,
    input  logic [trci_pkg::COL_W-1:0]  i_col0,
    input  logic [trci_pkg::COL_W-1:0]  i_col1,
    input  logic [trci_pkg::COL_W-1:0]  i_col2,
    output logic                        o_valid,
    output logic [COORD_BITS-1:0]       o_px,
    output logic [COORD_BITS-1:0]       o_py,
    output logic                        o_keep,
    output logic signed [NW-1:0]        o_num [3],
    output logic [DETW-1:0]             o_den
);
    localparam int CW = trci_pkg::CHAN_W;

    logic                   r4_valid, r4_keep, r4_neg;
    logic [COORD_BITS-1:0]  r4_px, r4_py;
    logic signed [DETW-1:0] r4_det;
    logic signed [NW-1:0]   r4_m0 [3];
    logic signed [NW-1:0]   r4_m1 [3];
    logic signed [NW-1:0]   r4_m2 [3];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r4_valid <= 1'b0;
            o_valid  <= 1'b0;
        end else if (i_adv) begin
            r4_valid <= i_valid;
            o_valid  <= r4_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_adv) begin
            r4_px   <= i_px;
            r4_py   <= i_py;
            r4_keep <= i_hit && (i_det != '0);
            r4_neg  <= i_det[DETW-1];
            r4_det  <= i_det;
            o_px    <= r4_px;
            o_py    <= r4_py;
            o_keep  <= r4_keep;
            o_den   <= r4_neg ? DETW'(-r4_det) : DETW'(r4_det);
        end
    end

    for (genvar k = 0; k < 3; k++) begin : g_chan
        logic [COLOR_BITS-1:0]   c0, c1, c2;
        logic signed [NW-1:0]    sum;

        assign c0 = COLOR_BITS'(i_col0[CW*(2-k) +: CW]);
        assign c1 = COLOR_BITS'(i_col1[CW*(2-k) +: CW]);
        assign c2 = COLOR_BITS'(i_col2[CW*(2-k) +: CW]);
        assign sum = r4_m0[k] + r4_m1[k] + r4_m2[k];

        always_ff @(posedge i_clk) begin
            if (i_adv) begin
                r4_m0[k] <= NW'($signed({1'b0, c0})) * NW'(i_det);
                r4_m1[k] <= NW'(i_pn) * NW'($signed({1'b0, c1}) - $signed({1'b0, c0}));
                r4_m2[k] <= NW'(i_qn) * NW'($signed({1'b0, c2}) - $signed({1'b0, c0}));
                o_num[k] <= r4_neg ? -sum : sum;
            end
        end
    end

endmodule

// File: hdl/trci_div.sv
// trci_div: restoring divider pipeline, one quotient bit per stage, then tint
// saturates the blend to the color range and drives the result register
// depends on trci_pkg
module trci_div #(
    parameter int COORD_BITS = trci_pkg::COORD_BITS_DEF,
    parameter int COLOR_BITS = trci_pkg::COLOR_BITS_DEF,
    parameter int NW         = 55,
    localparam int DETW = trci_pkg::DET_W
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_adv,
    input  logic                        i_valid,
    input  logic [COORD_BITS-1:0]       i_px,
    input  logic [COORD_BITS-1:0]       i_py,
    input  logic                        i_keep,
    input  logic signed [NW-1:0]        i_num [3],
    input  logic [DETW-1:0]             i_den,
    input  logic [trci_pkg::COL_W-1:0]  i_tint,
    output logic                        o_valid,
    output logic [trci_pkg::PIX_W-1:0]  o_x,
    output logic [trci_pkg::PIX_W-1:0]  o_y,
    output logic [trci_pkg::CHAN_W-1:0] o_chan [3]
);
    localparam int CW = trci_pkg::CHAN_W;
    localparam int NS = COLOR_BITS + 1;

    logic                   r_dv   [NS];
    logic                   r_keep [NS];
    logic [COORD_BITS-1:0]  r_x    [NS];
    logic [COORD_BITS-1:0]  r_y    [NS];
    logic [DETW-1:0]        r_den  [NS];
    logic [NW-1:0]          r_rem  [NS][3];
    logic [COLOR_BITS-1:0]  r_q    [NS][3];
    logic                   r_neg  [NS][3];
    logic                   r_sat  [NS][3];

    // entry stage: sign and overflow checks
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_dv[0] <= 1'b0;
        end else if (i_adv) begin
            r_dv[0] <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_adv) begin
            r_keep[0] <= i_keep;
            r_x[0]    <= i_px;
            r_y[0]    <= i_py;
            r_den[0]  <= i_den;
            for (int k = 0; k < 3; k++) begin
                r_rem[0][k] <= NW'(i_num[k]);
                r_q[0][k]   <= '0;
                r_neg[0][k] <= i_num[k][NW-1];
                r_sat[0][k] <= !i_num[k][NW-1] && (NW'(i_num[k]) >= (NW'(i_den) << COLOR_BITS));
            end
        end
    end

    // quotient bit COLOR_BITS-s in stage s
    for (genvar s = 1; s < NS; s++) begin : g_stage
        logic [NW-1:0]         shd;
        logic [NW-1:0]         n_rem [3];
        logic [COLOR_BITS-1:0] n_q   [3];

        assign shd = NW'(r_den[s-1]) << (COLOR_BITS - s);

        always_comb begin
            for (int k = 0; k < 3; k++) begin
                n_rem[k] = r_rem[s-1][k];
                n_q[k]   = r_q[s-1][k];
                if (r_rem[s-1][k] >= shd) begin
                    n_rem[k] = r_rem[s-1][k] - shd;
                    n_q[k][COLOR_BITS-s] = 1'b1;
                end
            end
        end

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_dv[s] <= 1'b0;
            end else if (i_adv) begin
                r_dv[s] <= r_dv[s-1];
            end
        end

        always_ff @(posedge i_clk) begin
            if (i_adv) begin
                r_keep[s] <= r_keep[s-1];
                r_x[s]    <= r_x[s-1];
                r_y[s]    <= r_y[s-1];
                r_den[s]  <= r_den[s-1];
                for (int k = 0; k < 3; k++) begin
                    r_rem[s][k] <= n_rem[k];
                    r_q[s][k]   <= n_q[k];
                    r_neg[s][k] <= r_neg[s-1][k];
                    r_sat[s][k] <= r_sat[s-1][k];
                end
            end
        end
    end

    // clamp, tint multiply and result register
    logic [COLOR_BITS-1:0]   v    [3];
    logic [2*COLOR_BITS-1:0] prod [3];

    always_comb begin
        for (int k = 0; k < 3; k++) begin
            if (r_neg[NS-1][k]) begin
                v[k] = '0;
            end else if (r_sat[NS-1][k]) begin
                v[k] = '1;
            end else begin
                v[k] = r_q[NS-1][k];
            end
            prod[k] = (2*COLOR_BITS)'(v[k]) * (2*COLOR_BITS)'(COLOR_BITS'(i_tint[CW*(2-k) +: CW]));
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            o_valid <= 1'b0;
        end else if (i_adv) begin
            o_valid <= r_dv[NS-1] && r_keep[NS-1];
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_adv) begin
            o_x <= trci_pkg::PIX_W'(r_x[NS-1]);
            o_y <= trci_pkg::PIX_W'(r_y[NS-1]);
            for (int k = 0; k < 3; k++) begin
                o_chan[k] <= CW'(prod[k][2*COLOR_BITS-1:COLOR_BITS]);
            end
        end
    end

endmodule

// File: hdl/triangle_raster_color_interpolate_unit.sv
// triangle_raster_color_interpolate_unit: covers pixels of one configured
// triangle and returns the tinted barycentric color of each covered pixel.
// Depends on trci_pkg, trci_pix_if, trci_res_if, trci_front, trci_blend, trci_div.
//
// Usage: write the three vertices, the tint and the three vertex colors on
// the config port (i_cfg_we, i_cfg_idx, i_cfg_data) while no pixel is in
// flight. Then stream pixel coordinates on i_pix, one transaction per cycle.
// Each covered pixel of a non-degenerate triangle gives one transaction on
// o_res; uncovered pixels give none and leave no gap in the input side.
// Throughput is one pixel per clock unless o_res stalls, set by a single
// pipeline in which the quotient takes one stage per color bit.
// Reset clears all config registers to zero and empties the pipeline.
// When o_res.ready is low with a result waiting, the whole pipeline holds
// and i_pix.ready drops; nothing in flight is lost or repeated.
module triangle_raster_color_interpolate_unit #(
    parameter int COORD_BITS    = trci_pkg::COORD_BITS_DEF,
    parameter int FRACTION_BITS = trci_pkg::FRACTION_BITS_DEF,
    parameter int COLOR_BITS    = trci_pkg::COLOR_BITS_DEF
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_cfg_we,
    input  logic [trci_pkg::IDX_W-1:0]   i_cfg_idx,
    input  logic [trci_pkg::CFG_W-1:0]   i_cfg_data,
    trci_pix_if.sink                     i_pix,
    trci_res_if.source                   o_res
);
    localparam int XW   = COORD_BITS + FRACTION_BITS;
    localparam int DW   = ((XW + 1 > trci_pkg::VC_W + 1) ? XW + 1 : trci_pkg::VC_W + 1) + 1;
    localparam int PNW  = trci_pkg::VC_W + 1 + DW + 1;
    localparam int NW   = PNW + COLOR_BITS + 3;
    localparam int DETW = trci_pkg::DET_W;

    logic [trci_pkg::VTX_W-1:0] r_vtx_a, r_vtx_b, r_vtx_c;
    logic [trci_pkg::COL_W-1:0] r_tint, r_col0, r_col1, r_col2;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vtx_a <= '0;
            r_vtx_b <= '0;
            r_vtx_c <= '0;
            r_tint  <= '0;
            r_col0  <= '0;
            r_col1  <= '0;
            r_col2  <= '0;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                trci_pkg::REG_VERTEX_A:     r_vtx_a <= trci_pkg::VTX_W'(i_cfg_data);
                trci_pkg::REG_VERTEX_B:     r_vtx_b <= trci_pkg::VTX_W'(i_cfg_data);
                trci_pkg::REG_VERTEX_C:     r_vtx_c <= trci_pkg::VTX_W'(i_cfg_data);
                trci_pkg::REG_TINT:         r_tint  <= i_cfg_data;
                trci_pkg::REG_COLOR_FIRST:  r_col0  <= i_cfg_data;
                trci_pkg::REG_COLOR_SECOND: r_col1  <= i_cfg_data;
                trci_pkg::REG_COLOR_THIRD:  r_col2  <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // whole pipeline moves when the result register is free or being taken
    logic adv;
    assign adv = !o_res.valid || o_res.ready;
    assign i_pix.ready = adv;

    logic                   f_valid, f_hit;
    logic [COORD_BITS-1:0]  f_px, f_py;
    logic signed [PNW-1:0]  f_pn, f_qn;
    logic signed [DETW-1:0] f_det;

    trci_front #(
        .COORD_BITS    (COORD_BITS),
        .FRACTION_BITS (FRACTION_BITS)
    ) u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_adv   (adv),
        .i_valid (i_pix.valid),
        .i_px    (COORD_BITS'(i_pix.pixel_x)),
        .i_py    (COORD_BITS'(i_pix.pixel_y)),
        .i_vtx_a (r_vtx_a),
        .i_vtx_b (r_vtx_b),
        .i_vtx_c (r_vtx_c),
        .o_valid (f_valid),
        .o_px    (f_px),
        .o_py    (f_py),
        .o_hit   (f_hit),
        .o_pn    (f_pn),
        .o_qn    (f_qn),
        .o_det   (f_det)
    );

    logic                   b_valid, b_keep;
    logic [COORD_BITS-1:0]  b_px, b_py;
    logic signed [NW-1:0]   b_num [3];
    logic [DETW-1:0]        b_den;

    trci_blend #(
        .COORD_BITS (COORD_BITS),
        .COLOR_BITS (COLOR_BITS),
        .PNW        (PNW)
    ) u_blend (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_adv   (adv),
        .i_valid (f_valid),
        .i_px    (f_px),
        .i_py    (f_py),
        .i_hit   (f_hit),
        .i_pn    (f_pn),
        .i_qn    (f_qn),
        .i_det   (f_det),
        .i_col0  (r_col0),
        .i_col1  (r_col1),
        .i_col2  (r_col2),
        .o_valid (b_valid),
        .o_px    (b_px),
        .o_py    (b_py),
        .o_keep  (b_keep),
        .o_num   (b_num),
        .o_den   (b_den)
    );

    logic [trci_pkg::CHAN_W-1:0] d_chan [3];

    trci_div #(
        .COORD_BITS (COORD_BITS),
        .COLOR_BITS (COLOR_BITS),
        .NW         (NW)
    ) u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_adv   (adv),
        .i_valid (b_valid),
        .i_px    (b_px),
        .i_py    (b_py),
        .i_keep  (b_keep),
        .i_num   (b_num),
        .i_den   (b_den),
        .i_tint  (r_tint),
        .o_valid (o_res.valid),
        .o_x     (o_res.out_x),
        .o_y     (o_res.out_y),
        .o_chan  (d_chan)
    );

    assign o_res.red   = d_chan[0];
    assign o_res.green = d_chan[1];
    assign o_res.blue  = d_chan[2];

endmodule
